@@ sv/lgrs_pkg.sv @@
`default_nettype none

package lgrs_pkg;

    // fixed field widths of the streaming channels
    localparam int ROW_BITS      = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int LIMIT_BITS    = 4;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int NBR_COUNT_W   = 4;

    // default column count of the grid
    localparam int ROW_CELLS_DEF = 64;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // register reset values
    localparam logic                  RULE_MODE_RST    = 1'b0;
    localparam logic [LIMIT_BITS-1:0] BIRTH_LIMIT_RST  = 4'd4;
    localparam logic [LIMIT_BITS-1:0] DEATH_LIMIT_RST  = 4'd3;
    localparam logic [WIDTH_BITS-1:0] ACTIVE_WIDTH_RST = 7'd64;

    // standard life rule counts
    localparam logic [NBR_COUNT_W-1:0] SURVIVE_LOW = 4'd2;
    localparam logic [NBR_COUNT_W-1:0] BIRTH_EXACT = 4'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RULE_MODE    = 2'd0,
        REG_BIRTH_LIMIT  = 2'd1,
        REG_DEATH_LIMIT  = 2'd2,
        REG_ACTIVE_WIDTH = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_LIFE = 1'b0,
        MODE_CAVE = 1'b1
    } rule_mode_t;

    typedef struct packed {
        rule_mode_t            mode;
        logic [LIMIT_BITS-1:0] birth_limit;
        logic [LIMIT_BITS-1:0] death_limit;
    } rule_cfg_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                frame_end;
        logic                run_end;
    } result_t;

endpackage

`default_nettype wire

@@ sv/lgrs_lane.sv @@
`default_nettype none

module lgrs_lane (
    input  wire logic [7:0]           nbr,
    input  wire logic                 self_live,
    input  wire lgrs_pkg::rule_cfg_t  rule_cfg,
    output logic                      next_live
);
    import lgrs_pkg::*;

    logic [NBR_COUNT_W-1:0] count_c;

    always_comb begin
        count_c = '0;
        for (int k = 0; k < 8; k++) begin
            count_c = count_c + NBR_COUNT_W'(nbr[k]);
        end
    end

    always_comb begin
        case (rule_cfg.mode)
            MODE_LIFE: begin
                if (self_live) begin
                    next_live = (count_c == SURVIVE_LOW) || (count_c == BIRTH_EXACT);
                end else begin
                    next_live = (count_c == BIRTH_EXACT);
                end
            end
            MODE_CAVE: begin
                if (self_live) begin
                    next_live = (count_c >= rule_cfg.death_limit);
                end else begin
                    next_live = (count_c > rule_cfg.birth_limit);
                end
            end
            default: next_live = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lgrs_row_engine.sv @@
`default_nettype none

module lgrs_row_engine #(
    parameter int ROW_CELLS = lgrs_pkg::ROW_CELLS_DEF
) (
    input  wire logic [ROW_CELLS-1:0] up_row,
    input  wire logic [ROW_CELLS-1:0] mid_row,
    input  wire logic [ROW_CELLS-1:0] down_row,
    input  wire logic [ROW_CELLS-1:0] col_mask,
    input  wire lgrs_pkg::rule_cfg_t  rule_cfg,
    output logic [ROW_CELLS-1:0]      next_row
);
    import lgrs_pkg::*;

    // dead column padded on both sides, cell i sits at bit i+1
    logic [ROW_CELLS+1:0] up_pad;
    logic [ROW_CELLS+1:0] mid_pad;
    logic [ROW_CELLS+1:0] down_pad;
    logic [ROW_CELLS-1:0] lane_out;

    assign up_pad   = {1'b0, up_row, 1'b0};
    assign mid_pad  = {1'b0, mid_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    for (genvar i = 0; i < ROW_CELLS; i++) begin : g_lane
        lgrs_lane u_lane (
            .nbr       ({up_pad[i+2:i], mid_pad[i+2], mid_pad[i], down_pad[i+2:i]}),
            .self_live (mid_pad[i+1]),
            .rule_cfg  (rule_cfg),
            .next_live (lane_out[i])
        );
    end

    // merge the lanes, dropping columns outside the active width
    assign next_row = lane_out & col_mask;

endmodule

`default_nettype wire

@@ sv/life_generation_row_step.sv @@
// Next-generation row engine for a two-state cellular automaton.
// Rows of a frame enter top to bottom on the s_ channel, one row per
// transaction: s_tdata carries the row, s_tuser marks the top row and
// s_tlast the bottom row. Each row completes the neighbourhood of the row
// above it, whose next state leaves on the m_ channel; a bottom row also
// yields its own next state right after. m_tlast marks the bottom row of a
// frame, m_tuser the last result of a given input row.
// Rule and width are set through the cfg_ write port; the user must write
// them only while the block idles, which the block does not enforce. Every
// cell of a row is updated by its own lane in the accept cycle, so a result
// enters the queue as its row is taken. While s_tready is high the block
// takes one row per cycle; a frame of N rows yields N results. Results wait
// in a four-entry queue; s_tready drops while fewer than two entries are
// free, so when the receiver stalls the queue fills and the input is held
// off without loss. Reset (aresetn low, synchronous) empties the queue,
// forgets held rows and restores the register defaults.
`default_nettype none

module life_generation_row_step #(
    parameter int ROW_CELLS = lgrs_pkg::ROW_CELLS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [lgrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lgrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input rows
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lgrs_pkg::ROW_BITS-1:0]      s_tdata,   // [63:0] row_cells
    input  wire logic                               s_tuser,   // [0] first_row
    input  wire logic                               s_tlast,
    // next-generation rows
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lgrs_pkg::ROW_BITS-1:0]           m_tdata,   // [63:0] next_cells
    output logic                                    m_tuser,   // [0] run_end
    output logic                                    m_tlast
);
    import lgrs_pkg::*;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // configuration
    rule_mode_t            rule_mode_reg;
    logic [LIMIT_BITS-1:0] birth_limit_reg;
    logic [LIMIT_BITS-1:0] death_limit_reg;
    logic [WIDTH_BITS-1:0] active_width_reg;
    rule_cfg_t             rule_cfg;

    // row history
    logic [ROW_CELLS-1:0]  above_reg, above_next;
    logic [ROW_CELLS-1:0]  middle_reg, middle_next;
    logic [1:0]            held_reg, held_next;

    // result queue
    result_t               ent_reg [OUT_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  accept;
    logic                  pop;
    logic                  push_a;
    logic                  push_b;
    logic [1:0]            held_eff;
    logic [ROW_CELLS-1:0]  col_mask;
    logic [ROW_CELLS-1:0]  cur_row;
    logic [ROW_CELLS-1:0]  a_up;
    logic [ROW_CELLS-1:0]  a_mid;
    logic [ROW_CELLS-1:0]  b_up;
    logic [ROW_CELLS-1:0]  a_next;
    logic [ROW_CELLS-1:0]  b_next;
    result_t               res_a;
    result_t               res_b;
    logic [PTR_W-1:0]      b_addr;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    assign rule_cfg.mode        = rule_mode_reg;
    assign rule_cfg.birth_limit = birth_limit_reg;
    assign rule_cfg.death_limit = death_limit_reg;

    always_comb begin
        for (int i = 0; i < ROW_CELLS; i++) begin
            col_mask[i] = (WIDTH_BITS'(i) < active_width_reg);
        end
    end

    // a top row drops whatever was held
    assign held_eff = s_tuser ? HELD_NONE : held_reg;
    assign cur_row  = s_tdata[ROW_CELLS-1:0] & col_mask;
    assign push_a   = accept && (held_eff != HELD_NONE);
    assign push_b   = accept && s_tlast;

    assign a_up  = (held_eff == HELD_TWO) ? (above_reg & col_mask) : '0;
    assign a_mid = middle_reg & col_mask;
    assign b_up  = (held_eff != HELD_NONE) ? a_mid : '0;

    lgrs_row_engine #(.ROW_CELLS(ROW_CELLS)) u_engine_above (
        .up_row   (a_up),
        .mid_row  (a_mid),
        .down_row (cur_row),
        .col_mask (col_mask),
        .rule_cfg (rule_cfg),
        .next_row (a_next)
    );

    lgrs_row_engine #(.ROW_CELLS(ROW_CELLS)) u_engine_bottom (
        .up_row   (b_up),
        .mid_row  (cur_row),
        .down_row ('0),
        .col_mask (col_mask),
        .rule_cfg (rule_cfg),
        .next_row (b_next)
    );

    always_comb begin
        res_a.cells     = ROW_BITS'(a_next);
        res_a.frame_end = 1'b0;
        res_a.run_end   = !s_tlast;
        res_b.cells     = ROW_BITS'(b_next);
        res_b.frame_end = 1'b1;
        res_b.run_end   = 1'b1;
    end

    always_comb begin
        above_next  = above_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        if (accept) begin
            if (s_tlast) begin
                above_next  = '0;
                middle_next = '0;
                held_next   = HELD_NONE;
            end else begin
                above_next  = (held_eff != HELD_NONE) ? middle_reg : '0;
                middle_next = cur_row;
                held_next   = (held_eff != HELD_NONE) ? HELD_TWO : HELD_ONE;
            end
        end
    end

    assign b_addr      = push_a ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_a) + PTR_W'(push_b);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

    assign s_tready = (cnt_reg <= CNT_W'(OUT_DEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = ent_reg[rd_ptr_reg].cells;
    assign m_tlast  = ent_reg[rd_ptr_reg].frame_end;
    assign m_tuser  = ent_reg[rd_ptr_reg].run_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_mode_reg    <= rule_mode_t'(RULE_MODE_RST);
            birth_limit_reg  <= BIRTH_LIMIT_RST;
            death_limit_reg  <= DEATH_LIMIT_RST;
            active_width_reg <= ACTIVE_WIDTH_RST;
            held_reg         <= HELD_NONE;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            cnt_reg          <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RULE_MODE:    rule_mode_reg    <= rule_mode_t'(cfg_wdata[0]);
                    REG_BIRTH_LIMIT:  birth_limit_reg  <= cfg_wdata[LIMIT_BITS-1:0];
                    REG_DEATH_LIMIT:  death_limit_reg  <= cfg_wdata[LIMIT_BITS-1:0];
                    REG_ACTIVE_WIDTH: active_width_reg <= cfg_wdata[WIDTH_BITS-1:0];
                    default: ;
                endcase
            end
            held_reg   <= held_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        above_reg  <= above_next;
        middle_reg <= middle_next;
        if (push_a) begin
            ent_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b) begin
            ent_reg[b_addr] <= res_b;
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import lgrs_pkg::*;

    localparam int ROWS_WANTED = 1950;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    // next-generation prediction for the row stream, with the rows still due
    class generation_tracker;
        localparam int COLS = ROW_CELLS_DEF;
        localparam logic [ROW_BITS-1:0] ALL_COLS =
            (COLS >= 64) ? {ROW_BITS{1'b1}} : ((64'd1 << COLS) - 64'd1);

        rule_mode_t              mode;
        logic [LIMIT_BITS-1:0]   birth;
        logic [LIMIT_BITS-1:0]   death;
        logic [WIDTH_BITS-1:0]   width;
        logic [ROW_BITS-1:0]     above;
        logic [ROW_BITS-1:0]     middle;
        int                      held;
        result_t                 due_rows[$];

        function new();
            mode   = rule_mode_t'(RULE_MODE_RST);
            birth  = BIRTH_LIMIT_RST;
            death  = DEATH_LIMIT_RST;
            width  = ACTIVE_WIDTH_RST;
            above  = '0;
            middle = '0;
            held   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_RULE_MODE:    mode  = rule_mode_t'(value[0]);
                REG_BIRTH_LIMIT:  birth = value[LIMIT_BITS-1:0];
                REG_DEATH_LIMIT:  death = value[LIMIT_BITS-1:0];
                REG_ACTIVE_WIDTH: width = value[WIDTH_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int due_count();
            return due_rows.size();
        endfunction

        function logic [ROW_BITS-1:0] width_mask();
            if (width >= COLS) return ALL_COLS;
            return ((64'd1 << width) - 64'd1) & ALL_COLS;
        endfunction

        function int cell_at(logic [ROW_BITS-1:0] row, int x);
            if (x < 0 || x > 63) return 0;
            return int'(row[x]);
        endfunction

        function logic [ROW_BITS-1:0] next_generation(logic [ROW_BITS-1:0] up,
                                                       logic [ROW_BITS-1:0] mid,
                                                       logic [ROW_BITS-1:0] down,
                                                       logic [ROW_BITS-1:0] mask);
            logic [ROW_BITS-1:0] res;
            int n;
            bit live;
            bit nxt;
            res = '0;
            for (int x = 0; x < 64; x++) begin
                n = cell_at(up, x - 1) + cell_at(up, x) + cell_at(up, x + 1)
                  + cell_at(mid, x - 1) + cell_at(mid, x + 1)
                  + cell_at(down, x - 1) + cell_at(down, x) + cell_at(down, x + 1);
                live = mid[x];
                if (mode == MODE_LIFE) begin
                    nxt = live ? (n == SURVIVE_LOW || n == BIRTH_EXACT) : (n == BIRTH_EXACT);
                end else begin
                    nxt = live ? (n >= death) : (n > birth);
                end
                res[x] = nxt;
            end
            return res & mask;
        endfunction

        function void take_row(logic [ROW_BITS-1:0] cells, bit first, bit last);
            logic [ROW_BITS-1:0] mask;
            logic [ROW_BITS-1:0] cur;
            logic [ROW_BITS-1:0] up;
            result_t res;
            mask = width_mask();
            cur  = cells & mask;
            if (first) begin
                above  = '0;
                middle = '0;
                held   = 0;
            end
            // incoming row completes the neighbourhood of the held row
            if (held != 0) begin
                up = (held >= 2) ? (above & mask) : '0;
                res.cells     = next_generation(up, middle & mask, cur, mask);
                res.frame_end = 1'b0;
                res.run_end   = !last;
                due_rows.push_back(res);
            end
            above  = (held != 0) ? middle : '0;
            middle = cur;
            held   = (held != 0) ? 2 : 1;
            if (last) begin
                up = (held >= 2) ? (above & mask) : '0;
                res.cells     = next_generation(up, cur, '0, mask);
                res.frame_end = 1'b1;
                res.run_end   = 1'b1;
                due_rows.push_back(res);
                above  = '0;
                middle = '0;
                held   = 0;
            end
        endfunction

        function string check_row(logic [ROW_BITS-1:0] cells, logic frame_end, logic run_end);
            result_t want;
            string msg;
            if (due_rows.size() == 0) return " result arrived with none due";
            want = due_rows.pop_front();
            msg = "";
            if (cells !== want.cells)
                msg = {msg, $sformatf(" next_cells %h want %h", cells, want.cells)};
            if (frame_end !== want.frame_end)
                msg = {msg, $sformatf(" frame_end %b want %b", frame_end, want.frame_end)};
            if (run_end !== want.run_end)
                msg = {msg, $sformatf(" run_end %b want %b", run_end, want.run_end)};
            return msg;
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ROW_BITS-1:0]    s_tdata = '0;   // [63:0] row_cells
    logic                   s_tuser = 1'b0; // [0] first_row
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [ROW_BITS-1:0]    m_tdata;        // [63:0] next_cells
    logic                   m_tuser;        // [0] run_end
    logic                   m_tlast;

    generation_tracker tracker = new();
    int  mismatches = 0;
    int  stall_cycles = 0;
    int  rows_sent = 0;
    bit  no_idle = 1'b0;
    bit  open_frame = 1'b0;

    life_generation_row_step #(
        .ROW_CELLS(ROW_CELLS_DEF)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 37);
    end

    task automatic report(input string msg);
        $display("%0t mismatch:%s", $time, msg);
        mismatches++;
    endtask

    // input and result transactions, both seen at the same edge
    always @(posedge aclk) begin
        string msg;
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.take_row(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                msg = tracker.check_row(m_tdata, m_tlast, m_tuser);
                if (msg != "") report(msg);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    task automatic send_row(input logic [ROW_BITS-1:0] cells, input bit first, input bit last);
        while (!no_idle && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        open_frame = !last;
        rows_sent++;
    endtask

    // hold the input off until every due row has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.due_count() != 0);
    endtask

    task automatic apply_config(input rule_mode_t mode, input logic [LIMIT_BITS-1:0] birth,
                                input logic [LIMIT_BITS-1:0] death,
                                input logic [WIDTH_BITS-1:0] width);
        logic [CFG_DATA_W-1:0] value[4];
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        // spare upper bits carry junk, only the low bits count
        value[REG_RULE_MODE]    = {6'($urandom_range(63)), mode};
        value[REG_BIRTH_LIMIT]  = {3'($urandom_range(7)), birth};
        value[REG_DEATH_LIMIT]  = {3'($urandom_range(7)), death};
        value[REG_ACTIVE_WIDTH] = width;
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= value[i];
            tracker.set_reg(cfg_reg_t'(i), value[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ROW_BITS-1:0] random_cells();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return a & b & {$urandom, $urandom};
            1: return a & b;
            2: return a | b;
            3: return ($urandom_range(1) != 0) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    function automatic logic [LIMIT_BITS-1:0] random_limit();
        if ($urandom_range(1) != 0) return LIMIT_BITS'($urandom_range(2, 6));
        return LIMIT_BITS'($urandom_range(15));
    endfunction

    function automatic logic [WIDTH_BITS-1:0] random_width();
        case ($urandom_range(9))
            0: return WIDTH_BITS'($urandom_range(3));
            1: return WIDTH_BITS'($urandom_range(65, 127));
            2: return WIDTH_BITS'(64);
            default: return WIDTH_BITS'($urandom_range(4, 64));
        endcase
    endfunction

    task automatic phase_config(input int phase);
        case (phase)
            0: apply_config(MODE_CAVE, 4'd15, 4'd0, 7'd64);
            1: apply_config(MODE_CAVE, 4'd0, 4'd15, 7'd64);
            2: apply_config(MODE_CAVE, 4'd8, 4'd9, 7'd40);
            3: apply_config(MODE_LIFE, 4'd4, 4'd3, 7'd0);
            4: apply_config(MODE_LIFE, 4'd4, 4'd3, 7'd1);
            5: apply_config(MODE_CAVE, 4'd4, 4'd3, 7'd127);
            6: apply_config(MODE_LIFE, 4'd4, 4'd3, 7'd3);
            default: apply_config(rule_mode_t'($urandom_range(1)), random_limit(),
                                  random_limit(), random_width());
        endcase
    endtask

    task automatic send_frame();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (int r = 0; r < len; r++) begin
            send_row(random_cells(), r == 0, r == len - 1);
            if ($urandom_range(29) == 0) drain();
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 5);
        for (int r = 0; r < n; r++) begin
            send_row(random_cells(), $urandom_range(3) == 0, $urandom_range(3) == 0);
        end
    endtask

    initial begin
        int phase;
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // frame opened without a top mark straight after reset, all cells live
        send_row('1, 1'b0, 1'b0);
        send_row('1, 1'b0, 1'b0);
        send_row('1, 1'b0, 1'b1);
        // edge columns
        send_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b0, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
        // glider
        send_row(64'h0000_0000_0000_0002, 1'b1, 1'b0);
        send_row(64'h0000_0000_0000_0004, 1'b0, 1'b0);
        send_row(64'h0000_0000_0000_0007, 1'b0, 1'b0);
        send_row('0, 1'b0, 1'b1);
        // single-row frames
        send_row('1, 1'b1, 1'b1);
        send_row(64'h0000_0000_0000_0007, 1'b1, 1'b1);
        // top mark mid-frame throws away the held rows
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0, 1'b0);
        drain();
        send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0);
        send_row(64'hFFFF_0000_FFFF_0000, 1'b0, 1'b1);
        // rows after a bottom row with no top mark start a fresh frame
        send_row(64'h0000_0000_0038_0000, 1'b0, 1'b0);
        send_row(64'h0000_0000_0038_0000, 1'b0, 1'b0);
        send_row(64'h0000_0000_0038_0000, 1'b0, 1'b1);

        rows_sent = 0;
        phase = 0;
        while (rows_sent < ROWS_WANTED) begin
            phase_config(phase);
            no_idle = (phase == 8 || phase == 9);
            target = rows_sent + $urandom_range(60, 140);
            while (rows_sent < target) begin
                if ($urandom_range(9) < 8) send_frame();
                else send_noise();
            end
            // close the frame so the next settings start clean
            if (open_frame) send_row(random_cells(), 1'b0, 1'b1);
            phase++;
        end
        no_idle = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.due_count() != 0) report(" results still due at the end");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
